// ===== rtl/two_level_page_table_manager_assert.svh =====
// Assertion macros shared by the verification files of the page table manager.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define TLPTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page table manager assertion failed");

// Next-cycle implication, off while reset is held
`define TLPTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page table manager assertion failed");

// Next-cycle implication that also covers reset itself
`define TLPTM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("page table manager assertion failed");

`endif

// ===== rtl/tlptm_pkg.sv =====
// Shared types and constants of the two-level page table manager.
// Used by the top level, the operation decoder and the checker.
`default_nettype none

package tlptm_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int IDX_W    = 10;
    localparam int FRAME_W  = 20;
    localparam int FLAG_W   = 12;
    localparam int ENTRY_W  = FRAME_W + FLAG_W;
    localparam int STATUS_W = 3;

    // Default geometry
    localparam int DIR_ENTRIES_DEF   = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Entry bit layout: frame in the upper bits, flags below
    localparam int PROTECT_BIT = 9;
    localparam int PRESENT_BIT = 0;
    localparam logic [ENTRY_W-1:0] PROTECT_MASK = ENTRY_W'(1) << PROTECT_BIT;

    typedef enum logic [OP_W-1:0] {
        OP_MAP       = 3'd0,
        OP_UNMAP     = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_PROTECT   = 3'd3,
        OP_UNPROTECT = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_TABLE  = 3'd1,
        ST_NO_PAGE   = 3'd2,
        ST_MAPPED    = 3'd3,
        ST_PROTECTED = 3'd4
    } t_status;

    // Outcome of one operation: write-back controls plus the result
    typedef struct packed {
        logic                page_we;
        logic [ENTRY_W-1:0]  page_data;
        logic                table_we;
        t_status             status;
        logic [FRAME_W-1:0]  frame;
    } t_exec_res;

endpackage

`default_nettype wire

// ===== rtl/tlptm_exec.sv =====
// Operation decoder: from the fetched entry and directory bit, decide the
// write-back and the result. Depends on tlptm_pkg.
`default_nettype none

module tlptm_exec (
    input  wire logic [tlptm_pkg::OP_W-1:0]    i_op,
    input  wire logic                          i_dir_oor,
    input  wire logic                          i_page_oor,
    input  wire logic                          i_tbl,
    input  wire logic [tlptm_pkg::ENTRY_W-1:0] i_entry,
    input  wire logic [tlptm_pkg::FRAME_W-1:0] i_frame,
    input  wire logic [tlptm_pkg::FLAG_W-1:0]  i_flags,
    output tlptm_pkg::t_exec_res               o_res
);

    tlptm_pkg::t_op                  op_code;
    logic                            present;
    logic                            valid_op;
    logic [tlptm_pkg::FRAME_W-1:0]   entry_frame;

    assign op_code     = tlptm_pkg::t_op'(i_op);
    assign present     = i_entry[tlptm_pkg::PRESENT_BIT];
    assign entry_frame = i_entry[tlptm_pkg::ENTRY_W-1:tlptm_pkg::FLAG_W];

    // Operation codes that name a known operation
    always_comb begin
        unique case (op_code) inside
            tlptm_pkg::OP_MAP, tlptm_pkg::OP_UNMAP, tlptm_pkg::OP_TRANSLATE,
            tlptm_pkg::OP_PROTECT, tlptm_pkg::OP_UNPROTECT: valid_op = 1'b1;
            default: valid_op = 1'b0;
        endcase
    end

    // Decide status, returned frame and write-back
    always_comb begin
        o_res.page_we   = 1'b0;
        o_res.page_data = i_entry;
        o_res.table_we  = 1'b0;
        o_res.status    = tlptm_pkg::ST_OK;
        o_res.frame     = '0;

        if (!valid_op) begin
            // unknown code: no effect, plain ok
        end else if (i_dir_oor) begin
            o_res.status = tlptm_pkg::ST_NO_TABLE;
        end else if (i_page_oor) begin
            o_res.status = tlptm_pkg::ST_NO_PAGE;
        end else if (op_code == tlptm_pkg::OP_MAP) begin
            // create the table; an entry of a fresh table reads as zero
            o_res.table_we = !i_tbl;
            if (present) begin
                o_res.status = tlptm_pkg::ST_MAPPED;
            end else begin
                o_res.page_we   = 1'b1;
                o_res.page_data = {i_frame, i_flags};
            end
        end else if (!i_tbl) begin
            o_res.status = tlptm_pkg::ST_NO_TABLE;
        end else if (!present) begin
            o_res.status = tlptm_pkg::ST_NO_PAGE;
        end else begin
            unique case (op_code)
                tlptm_pkg::OP_UNMAP: begin
                    if ((i_entry & tlptm_pkg::PROTECT_MASK) != '0) begin
                        o_res.status = tlptm_pkg::ST_PROTECTED;
                    end else begin
                        o_res.frame     = entry_frame;
                        o_res.page_we   = 1'b1;
                        o_res.page_data = '0;
                    end
                end
                tlptm_pkg::OP_TRANSLATE: begin
                    o_res.frame = entry_frame;
                end
                tlptm_pkg::OP_PROTECT: begin
                    o_res.page_we   = 1'b1;
                    o_res.page_data = i_entry | tlptm_pkg::PROTECT_MASK;
                end
                default: begin
                    o_res.page_we   = 1'b1;
                    o_res.page_data = i_entry & ~tlptm_pkg::PROTECT_MASK;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/two_level_page_table_manager.sv =====
// A request is captured with its memory reads on accept; the result is
// registered when the execute state finishes, which waits while a held
// result is stalled. A new request is taken only in idle, after the last
// has finished; the entry memory has one read and one write port. Reset:
// synchronous; then a clearing pass over all DEPTH entries (1048576 by default)
// zeroes both memories while o_in_stall is high. Depends on tlptm_pkg and tlptm_exec.
`default_nettype none

module two_level_page_table_manager #(
    parameter int DIR_ENTRIES   = tlptm_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tlptm_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output      logic                            o_in_stall,
    input  wire logic [tlptm_pkg::OP_W-1:0]      i_op,
    input  wire logic [tlptm_pkg::IDX_W-1:0]     i_dir_index,
    input  wire logic [tlptm_pkg::IDX_W-1:0]     i_page_index,
    input  wire logic [tlptm_pkg::FRAME_W-1:0]   i_phys_frame,
    input  wire logic [tlptm_pkg::FLAG_W-1:0]    i_entry_flags,
    // result channel
    output      logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    output      logic [tlptm_pkg::STATUS_W-1:0]  o_status,
    output      logic [tlptm_pkg::FRAME_W-1:0]   o_frame_out
);

    localparam int DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
    localparam int DW    = $clog2(DIR_ENTRIES);
    localparam int PW    = $clog2(TABLE_ENTRIES);
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = tlptm_pkg::IDX_W + 1;

    localparam logic [LW-1:0] DIR_LIM   = LW'(DIR_ENTRIES);
    localparam logic [LW-1:0] PAGE_LIM  = LW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] T_MUL     = AW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [DW-1:0] DIR_LAST  = DW'(DIR_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // memories
    logic [tlptm_pkg::ENTRY_W-1:0] r_page_mem  [DEPTH];
    logic                          r_table_mem [DIR_ENTRIES];

    // clearing pass counters
    logic [AW-1:0] r_clr_cnt, n_clr_cnt;
    logic [DW-1:0] r_dclr,    n_dclr;

    // request held for the execute state
    logic [tlptm_pkg::OP_W-1:0]    r_op;
    logic [DW-1:0]                 r_dir;
    logic [AW-1:0]                 r_addr;
    logic                          r_dir_oor;
    logic                          r_page_oor;
    logic [tlptm_pkg::FRAME_W-1:0] r_frame;
    logic [tlptm_pkg::FLAG_W-1:0]  r_flags;

    // memory read data
    logic [tlptm_pkg::ENTRY_W-1:0] r_rd_entry;
    logic                          r_rd_tbl;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [tlptm_pkg::STATUS_W-1:0]  r_status;
    logic [tlptm_pkg::FRAME_W-1:0]   r_frame_out;

    logic                    accept;
    logic                    finish;
    logic                    dir_oor;
    logic                    page_oor;
    logic [DW-1:0]           rd_dir;
    logic [AW-1:0]           dir_base;
    logic [AW-1:0]           rd_addr;
    tlptm_pkg::t_exec_res    exec_res;

    // handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign finish     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // range checks and entry address of the incoming request
    assign dir_oor  = ({1'b0, i_dir_index} >= DIR_LIM);
    assign page_oor = ({1'b0, i_page_index} >= PAGE_LIM);
    assign rd_dir   = dir_oor ? '0 : i_dir_index[DW-1:0];
    assign dir_base = AW'(rd_dir) * T_MUL;
    assign rd_addr  = (dir_oor || page_oor) ? '0
                    : AW'(dir_base + AW'(i_page_index[PW-1:0]));

    // sequence clear, idle and execute
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_dclr    = r_dclr;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_cnt = AW'(r_clr_cnt + AW'(1));
                if (r_dclr != DIR_LAST) begin
                    n_dclr = DW'(r_dclr + DW'(1));
                end
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_dclr    <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_dclr    <= n_dclr;
        end
    end

    // capture the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_op;
            r_dir      <= rd_dir;
            r_addr     <= rd_addr;
            r_dir_oor  <= dir_oor;
            r_page_oor <= page_oor;
            r_frame    <= i_phys_frame;
            r_flags    <= i_entry_flags;
        end
    end

    // entry memory: read on accept, write back on finish or clear
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_entry <= r_page_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_page_mem[r_clr_cnt] <= '0;
        end else if (finish && exec_res.page_we) begin
            r_page_mem[r_addr] <= exec_res.page_data;
        end
    end

    // directory memory: same access pattern
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_tbl <= r_table_mem[rd_dir];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_table_mem[r_dclr] <= 1'b0;
        end else if (finish && exec_res.table_we) begin
            r_table_mem[r_dir] <= 1'b1;
        end
    end

    // decode the operation against the fetched state
    tlptm_exec u_exec (
        .i_op       (r_op),
        .i_dir_oor  (r_dir_oor),
        .i_page_oor (r_page_oor),
        .i_tbl      (r_rd_tbl),
        .i_entry    (r_rd_entry),
        .i_frame    (r_frame),
        .i_flags    (r_flags),
        .o_res      (exec_res)
    );

    // output register: load on finish, drop when taken
    always_comb begin
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status    <= exec_res.status;
            r_frame_out <= exec_res.frame;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_frame_out = r_frame_out;

endmodule

`default_nettype wire

// ===== rtl/tlptm_checker.sv =====
// Port-level checker for the page table manager, bound to the top level.
// Depends on tlptm_pkg and the assertion macro header.
`default_nettype none

`include "two_level_page_table_manager_assert.svh"

module tlptm_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic [tlptm_pkg::OP_W-1:0]      i_op,
    input wire logic [tlptm_pkg::IDX_W-1:0]     i_dir_index,
    input wire logic [tlptm_pkg::IDX_W-1:0]     i_page_index,
    input wire logic [tlptm_pkg::FRAME_W-1:0]   i_phys_frame,
    input wire logic [tlptm_pkg::FLAG_W-1:0]    i_entry_flags,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [tlptm_pkg::STATUS_W-1:0]  o_status,
    input wire logic [tlptm_pkg::FRAME_W-1:0]   o_frame_out
);

    logic in_accept;
    logic unused_payload;

    assign in_accept      = i_in_valid && !o_in_stall;
    assign unused_payload = ^{i_op, i_dir_index, i_page_index, i_phys_frame, i_entry_flags};

    // reset starts the clearing pass with nothing in flight
    `TLPTM_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, o_in_stall && !o_out_valid)

    // one request at a time: stall right after an accept
    `TLPTM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_accept, o_in_stall)

    // a failed request returns frame zero
    `TLPTM_ASSERT_SAME(a_fail_frame_zero, i_clk, i_rst_n, o_out_valid && (o_status != tlptm_pkg::ST_OK), o_frame_out == '0)

    // a stalled result holds
    `TLPTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_frame_out))

endmodule

bind two_level_page_table_manager tlptm_checker u_tlptm_checker (.*);

`default_nettype wire
